@@ rtl/cos_pkg.sv @@
`timescale 1ns / 1ps

package cos_pkg;

  // Field and datapath widths.
  localparam int PixW     = 8;
  localparam int SumW     = 10;
  localparam int ProdW    = 24;
  localparam int QBits    = 16;
  localparam int OppW     = 20;
  localparam int NumLanes = 3;
  localparam int OutShift = 9;
  localparam int AddrW    = 3;
  localparam int DataW    = 32;

  // Input register, one cell per quotient bit, opponent stage, output register.
  localparam int Latency = QBits + 3;

  // 255.0 in Q8.8.
  localparam logic [QBits-1:0] NormScale = 16'd65280;
  localparam logic [PixW-1:0]  OutMax    = 8'd255;

  // Register map: word index taken from paddr[2].
  localparam logic RegDarkThreshold = 1'b0;
  localparam logic [PixW-1:0] DarkThresholdReset = 8'd60;

  // Lane indexes.
  localparam int LaneRed   = 0;
  localparam int LaneGreen = 1;
  localparam int LaneBlue  = 2;

  // One lane of the divider: partial remainder and the shared
  // dividend/quotient shift register.
  typedef struct packed {
    logic [SumW-1:0]  rem;
    logic [QBits-1:0] acc;
  } lane_t;

  // Everything that travels down the divider chain with one item.
  typedef struct packed {
    lane_t [NumLanes-1:0] lane;
    logic [SumW-1:0]      sum;
    logic                 dark;
    logic                 ygate;
  } cell_t;

  // Integer part of a Q8.9 value, clamped to 0..255.
  function automatic logic [PixW-1:0] to_out(input logic signed [OppW-1:0] v);
    logic [OppW-1:0] q;
    q = OppW'(v) >> OutShift;
    if (v <= 0) begin
      return '0;
    end
    if (q > OppW'(OutMax)) begin
      return OutMax;
    end
    return q[PixW-1:0];
  endfunction

endpackage

@@ rtl/cos_div_cell.sv @@
`timescale 1ns / 1ps

module cos_div_cell
  import cos_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  cell_t in_cell,
  output logic  out_valid,
  output cell_t out_cell
);

  cell_t cell_next;

  // One restoring division step on each lane: bring in the next dividend
  // bit, subtract the divisor if it fits, and shift the quotient bit in.
  always_comb begin
    logic [SumW:0] shifted;
    logic          fits;
    cell_next = in_cell;
    for (int k = 0; k < NumLanes; k++) begin
      shifted = {in_cell.lane[k].rem, in_cell.lane[k].acc[QBits-1]};
      fits    = shifted >= {1'b0, in_cell.sum};
      if (fits) begin
        shifted = shifted - {1'b0, in_cell.sum};
      end
      cell_next.lane[k].rem = shifted[SumW-1:0];
      cell_next.lane[k].acc = {in_cell.lane[k].acc[QBits-2:0], fits};
    end
  end

  // Valid flag is control state; the payload needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_cell <= cell_next;
  end

endmodule

@@ rtl/cos_opponent.sv @@
`timescale 1ns / 1ps

module cos_opponent
  import cos_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  cell_t           in_cell,
  output logic            done,
  output logic [PixW-1:0] salience,
  output logic [PixW-1:0] red_opponent,
  output logic [PixW-1:0] green_opponent,
  output logic [PixW-1:0] blue_opponent
);

  logic                   opp_valid;
  logic signed [OppW-1:0] ro;
  logic signed [OppW-1:0] go;
  logic signed [OppW-1:0] bo;
  logic signed [OppW-1:0] yw;
  logic signed [OppW-1:0] ro_next;
  logic signed [OppW-1:0] go_next;
  logic signed [OppW-1:0] bo_next;
  logic signed [OppW-1:0] yw_next;
  logic signed [OppW-1:0] smax;

  // Opponents and the yellow term at Q8.9; a dark item forces all to zero.
  always_comb begin
    logic signed [OppW-1:0] rn;
    logic signed [OppW-1:0] gn;
    logic signed [OppW-1:0] bn;
    logic signed [OppW-1:0] mn;
    rn = signed'(OppW'(in_cell.lane[LaneRed].acc));
    gn = signed'(OppW'(in_cell.lane[LaneGreen].acc));
    bn = signed'(OppW'(in_cell.lane[LaneBlue].acc));
    mn = (rn < gn) ? rn : gn;
    ro_next = (rn <<< 1) - gn - bn;
    go_next = (gn <<< 1) - rn - bn;
    bo_next = (bn <<< 1) - rn - gn;
    yw_next = in_cell.ygate ? (((mn <<< 1) - bn) <<< 1) : '0;
    if (in_cell.dark) begin
      ro_next = '0;
      go_next = '0;
      bo_next = '0;
      yw_next = '0;
    end
  end

  // Largest of zero, the three opponents and yellow.
  always_comb begin
    smax = '0;
    if (ro > smax) smax = ro;
    if (go > smax) smax = go;
    if (yw > smax) smax = yw;
    if (bo > smax) smax = bo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      opp_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      opp_valid <= in_valid;
      done      <= opp_valid;
    end
  end

  // Opponent registers, then the output register.
  always_ff @(posedge clk) begin
    ro             <= ro_next;
    go             <= go_next;
    bo             <= bo_next;
    yw             <= yw_next;
    salience       <= to_out(smax);
    red_opponent   <= to_out(ro);
    green_opponent <= to_out(go);
    blue_opponent  <= to_out(bo);
  end

  // Salience is never below any opponent output.
  a_sal_max: assert property (@(posedge clk) disable iff (rst)
    done |-> (salience >= red_opponent && salience >= green_opponent &&
              salience >= blue_opponent))
    else $error("salience below an opponent output");

  // A dark item gives all zeros once it has passed the opponent and output registers.
  a_dark_zero: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_cell.dark) |-> ##2 (salience == '0 && red_opponent == '0 &&
                                        green_opponent == '0 && blue_opponent == '0))
    else $error("dark item gave nonzero output");

  // Output strobe follows an opponent-stage item in the next cycle.
  a_done_follow: assert property (@(posedge clk) disable iff (rst)
    opp_valid |=> done)
    else $error("opponent stage item lost");

endmodule

@@ rtl/color_opponent_salience.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// pixel     in         start, busy               red_in, green_in, blue_in
// result    out        done (one-cycle strobe)   salience, red/green/blue_opponent
// config    in/out     APB psel/penable/pwrite   paddr, pwdata, prdata, pready
//
// One pixel per clock. From start to done an item passes the input register,
// the divider chain of one cell per quotient bit (16), the opponent register
// and the output register.
// busy is always low; rst (synchronous) empties the pipeline and loads
// dark_threshold with 60. The receiver cannot stall the result strobe.
module color_opponent_salience
  import cos_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [PixW-1:0]  red_in,
  input  logic [PixW-1:0]  green_in,
  input  logic [PixW-1:0]  blue_in,
  output logic             done,
  output logic [PixW-1:0]  salience,
  output logic [PixW-1:0]  red_opponent,
  output logic [PixW-1:0]  green_opponent,
  output logic [PixW-1:0]  blue_opponent,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  logic [PixW-1:0] dark_threshold;
  logic            in_valid;
  cell_t           in_cell;
  cell_t           in_cell_next;
  logic            chain_valid [QBits+1];
  cell_t           chain_cell  [QBits+1];

  assign busy   = 1'b0;
  assign pready = 1'b1;

  // Configuration register: written on the APB access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      dark_threshold <= DarkThresholdReset;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == RegDarkThreshold) begin
      dark_threshold <= pwdata[PixW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == RegDarkThreshold) begin
      prdata = DataW'(dark_threshold);
    end
  end

  // Input stage: channel sum, dark test, yellow gate and the scaled
  // dividends 65280*c split into initial remainder and shift bits.
  always_comb begin
    logic [SumW-1:0]  sum;
    logic [SumW-1:0]  thr3;
    logic [SumW-1:0]  r2;
    logic [SumW-1:0]  g2;
    logic [SumW-1:0]  b3;
    logic [ProdW-1:0] pr;
    logic [ProdW-1:0] pg;
    logic [ProdW-1:0] pb;
    sum  = SumW'(red_in) + SumW'(green_in) + SumW'(blue_in);
    thr3 = (SumW'(dark_threshold) << 1) + SumW'(dark_threshold);
    r2   = SumW'(red_in) << 1;
    g2   = SumW'(green_in) << 1;
    b3   = (SumW'(blue_in) << 1) + SumW'(blue_in);
    pr   = ProdW'(red_in) * ProdW'(NormScale);
    pg   = ProdW'(green_in) * ProdW'(NormScale);
    pb   = ProdW'(blue_in) * ProdW'(NormScale);
    in_cell_next.sum   = sum;
    in_cell_next.dark  = (sum == '0) || (sum < thr3);
    in_cell_next.ygate = (r2 > b3) && (g2 > b3);
    in_cell_next.lane[LaneRed].rem   = SumW'(pr[ProdW-1:QBits]);
    in_cell_next.lane[LaneRed].acc   = pr[QBits-1:0];
    in_cell_next.lane[LaneGreen].rem = SumW'(pg[ProdW-1:QBits]);
    in_cell_next.lane[LaneGreen].acc = pg[QBits-1:0];
    in_cell_next.lane[LaneBlue].rem  = SumW'(pb[ProdW-1:QBits]);
    in_cell_next.lane[LaneBlue].acc  = pb[QBits-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    in_cell <= in_cell_next;
  end

  // Divider chain: one cell per quotient bit.
  assign chain_valid[0] = in_valid;
  assign chain_cell[0]  = in_cell;

  for (genvar i = 0; i < QBits; i++) begin : g_cell
    cos_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[i]),
      .in_cell   (chain_cell[i]),
      .out_valid (chain_valid[i+1]),
      .out_cell  (chain_cell[i+1])
    );
  end

  cos_opponent u_opponent (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (chain_valid[QBits]),
    .in_cell        (chain_cell[QBits]),
    .done           (done),
    .salience       (salience),
    .red_opponent   (red_opponent),
    .green_opponent (green_opponent),
    .blue_opponent  (blue_opponent)
  );

  // Every accepted item produces a result strobe.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##Latency done)
    else $error("accepted item did not produce a result");

  // No result strobe without a matching accepted item.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, Latency))
    else $error("result without a matching item");

  // A non-dark item leaving the chain has a remainder below the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (chain_valid[QBits] && !chain_cell[QBits].dark) |->
      (chain_cell[QBits].lane[LaneRed].rem < chain_cell[QBits].sum &&
       chain_cell[QBits].lane[LaneGreen].rem < chain_cell[QBits].sum &&
       chain_cell[QBits].lane[LaneBlue].rem < chain_cell[QBits].sum))
    else $error("divider remainder out of range");

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import cos_pkg::*;

  localparam int CycleLimit = 200000;
  localparam logic [AddrW-1:0] DarkThresholdAddr = AddrW'({RegDarkThreshold, 2'b00});

  // Pixel kinds for the random part.
  typedef enum int {
    PixUniform,
    PixYellowEdge,
    PixDarkEdge,
    PixDominant,
    PixFaint
  } pixel_kind_t;

  typedef struct packed {
    logic [PixW-1:0] red;
    logic [PixW-1:0] green;
    logic [PixW-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [PixW-1:0] salience;
    logic [PixW-1:0] red_opp;
    logic [PixW-1:0] green_opp;
    logic [PixW-1:0] blue_opp;
  } response_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  logic [PixW-1:0]  red_in = '0;
  logic [PixW-1:0]  green_in = '0;
  logic [PixW-1:0]  blue_in = '0;
  logic             done;
  logic [PixW-1:0]  salience;
  logic [PixW-1:0]  red_opponent;
  logic [PixW-1:0]  green_opponent;
  logic [PixW-1:0]  blue_opponent;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  pixel_t          pixel_q[$];
  response_t       response_q[$];
  logic [PixW-1:0] dark_thr = DarkThresholdReset;
  logic            taken = 1'b0;
  logic [DataW-1:0] readback;
  int              pixels_sent = 0;
  int              fail_count = 0;
  int              cycle_count = 0;

  color_opponent_salience uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .red_in(red_in),
    .green_in(green_in),
    .blue_in(blue_in),
    .done(done),
    .salience(salience),
    .red_opponent(red_opponent),
    .green_opponent(green_opponent),
    .blue_opponent(blue_opponent),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  // Integer part of a Q8.9 value, zero when not positive, capped at 255.
  function automatic logic [PixW-1:0] q89_to_pixel(input int v);
    int q;
    if (v <= 0) begin
      return '0;
    end
    q = v / 512;
    return (q > 255) ? 8'd255 : PixW'(q);
  endfunction

  // Opponent channels and salience of one pixel under a dark threshold.
  function automatic response_t predict_response(input pixel_t px, input logic [PixW-1:0] thr);
    response_t res;
    int r, g, b, sum, rn, gn, bn, ro, go, bo, yw, best;
    r = int'(px.red);
    g = int'(px.green);
    b = int'(px.blue);
    sum = r + g + b;
    res = '0;
    if (sum == 0 || sum < 3 * int'(thr)) begin
      return res;
    end
    // Normalized channels in Q8.8, 255.0 full scale.
    rn = (r * 65280) / sum;
    gn = (g * 65280) / sum;
    bn = (b * 65280) / sum;
    // Opponents and yellow at Q8.9 so the halves stay exact.
    ro = 2 * rn - gn - bn;
    go = 2 * gn - rn - bn;
    bo = 2 * bn - rn - gn;
    yw = 2 * (2 * ((rn < gn) ? rn : gn) - bn);
    if (!(2 * r > 3 * b) || !(2 * g > 3 * b)) begin
      yw = 0;
    end
    best = 0;
    if (ro > best) best = ro;
    if (go > best) best = go;
    if (yw > best) best = yw;
    if (bo > best) best = bo;
    res.salience  = q89_to_pixel(best);
    res.red_opp   = q89_to_pixel(ro);
    res.green_opp = q89_to_pixel(go);
    res.blue_opp  = q89_to_pixel(bo);
    return res;
  endfunction

  function automatic int clamp_pixel(input int v);
    return (v < 0) ? 0 : ((v > 255) ? 255 : v);
  endfunction

  task automatic queue_pixel(input int r, input int g, input int b);
    pixel_t px;
    px.red = PixW'(r);
    px.green = PixW'(g);
    px.blue = PixW'(b);
    pixel_q.insert(pixel_q.size(), px);
  endtask

  // Random pixel of a given kind, aimed at the decision edges of the block.
  task automatic queue_random_pixel(input pixel_kind_t kind);
    int r, g, b, t, rest, lvl, jit, hot;
    case (kind)
      PixYellowEdge: begin
        b = $urandom_range(0, 170);
        lvl = (3 * b) / 2;
        jit = $urandom_range(0, 3);
        r = clamp_pixel(lvl + jit - 1);
        jit = $urandom_range(0, 3);
        if ($urandom_range(0, 1) == 1) begin
          g = clamp_pixel(lvl + jit - 1);
        end else begin
          g = $urandom_range(clamp_pixel(lvl), 255);
        end
        if ($urandom_range(0, 1) == 1) begin
          t = r;
          r = g;
          g = t;
        end
      end
      PixDarkEdge: begin
        jit = $urandom_range(0, 4);
        t = 3 * int'(dark_thr) + jit - 2;
        t = (t < 0) ? 0 : ((t > 765) ? 765 : t);
        r = $urandom_range((t > 510) ? t - 510 : 0, (t > 255) ? 255 : t);
        rest = t - r;
        g = $urandom_range((rest > 255) ? rest - 255 : 0, (rest > 255) ? 255 : rest);
        b = rest - g;
      end
      PixDominant: begin
        hot = $urandom_range(0, 2);
        r = (hot == 0) ? $urandom_range(200, 255) : $urandom_range(0, 40);
        g = (hot == 1) ? $urandom_range(200, 255) : $urandom_range(0, 40);
        b = (hot == 2) ? $urandom_range(200, 255) : $urandom_range(0, 40);
      end
      PixFaint: begin
        r = $urandom_range(0, 3);
        g = $urandom_range(0, 3);
        b = $urandom_range(0, 3);
      end
      default: begin
        r = $urandom_range(0, 255);
        g = $urandom_range(0, 255);
        b = $urandom_range(0, 255);
      end
    endcase
    queue_pixel(r, g, b);
  endtask

  task automatic queue_random_batch(input int count);
    int roll;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) queue_random_pixel(PixUniform);
      else if (roll < 60) queue_random_pixel(PixYellowEdge);
      else if (roll < 80) queue_random_pixel(PixDarkEdge);
      else if (roll < 92) queue_random_pixel(PixDominant);
      else queue_random_pixel(PixFaint);
    end
  endtask

  // Hold the stimulus until the pipeline has drained.
  task automatic wait_for_drain();
    while (pixel_q.size() != 0 || start || response_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Write the threshold, then read it back in the following transfer.
  task automatic write_dark_threshold(input logic [PixW-1:0] value);
    logic [DataW-PixW-1:0] junk;
    junk = (DataW-PixW)'($urandom);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= DarkThresholdAddr;
    pwdata <= {junk, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    dark_thr = value;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (readback[PixW-1:0] !== value) begin
      $error("dark_threshold readback: expected %0d, got %0d", value, readback[PixW-1:0]);
      fail_count++;
    end
  endtask

  // Cycle counter and watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAIL color_opponent_salience");
      $finish;
    end
  end

  // Capture read data at the access edge.
  always @(posedge clk) begin
    if (psel && penable && pready && !pwrite) begin
      readback <= prdata;
    end
  end

  // Pixel driver: holds each item until it is taken, idles now and then.
  always @(negedge clk) begin
    pixel_t px;
    logic   quiet;
    logic   pause;
    quiet = (pixels_sent >= 400 && pixels_sent < 560);
    pause = !quiet && ($urandom_range(0, 99) < 6);
    if (rst) begin
      start <= 1'b0;
    end else if (!start || taken) begin
      if (pixel_q.size() != 0 && !pause) begin
        px = pixel_q[0];
        pixel_q.delete(0);
        start <= 1'b1;
        red_in <= px.red;
        green_in <= px.green;
        blue_in <= px.blue;
        pixels_sent++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Result monitor: predicts on acceptance, checks each strobe in order.
  always @(posedge clk) begin
    response_t want;
    if (rst) begin
      taken <= 1'b0;
    end else begin
      taken <= start && !busy;
      if (start && !busy) begin
        response_q.insert(response_q.size(),
                          predict_response({red_in, green_in, blue_in}, dark_thr));
      end
      if (done) begin
        if (response_q.size() == 0) begin
          $error("result with no pixel outstanding");
          fail_count++;
        end else begin
          want = response_q[0];
          response_q.delete(0);
          if (salience !== want.salience) begin
            $error("salience: expected %0d, got %0d", want.salience, salience);
            fail_count++;
          end
          if (red_opponent !== want.red_opp) begin
            $error("red_opponent: expected %0d, got %0d", want.red_opp, red_opponent);
            fail_count++;
          end
          if (green_opponent !== want.green_opp) begin
            $error("green_opponent: expected %0d, got %0d", want.green_opp, green_opponent);
            fail_count++;
          end
          if (blue_opponent !== want.blue_opp) begin
            $error("blue_opponent: expected %0d, got %0d", want.blue_opp, blue_opponent);
            fail_count++;
          end
        end
      end
    end
  end

  // Stimulus sequence and end of test.
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed pixels at the reset threshold.
    queue_pixel(0, 0, 0);
    queue_pixel(255, 255, 255);
    queue_pixel(255, 0, 0);
    queue_pixel(0, 255, 0);
    queue_pixel(0, 0, 255);
    queue_pixel(255, 255, 0);
    queue_pixel(0, 255, 255);
    queue_pixel(255, 0, 255);
    queue_pixel(60, 60, 59);
    queue_pixel(60, 60, 60);
    queue_pixel(150, 150, 100);
    queue_pixel(151, 151, 100);
    queue_pixel(151, 150, 100);
    queue_pixel(200, 201, 133);
    queue_pixel(200, 201, 134);
    queue_pixel(180, 0, 0);
    queue_pixel(179, 0, 0);
    queue_pixel(170, 85, 0);
    queue_pixel(85, 85, 170);
    queue_pixel(128, 127, 1);
    wait_for_drain();

    // Zero threshold: the all-zero pixel has nothing to normalize by.
    write_dark_threshold(8'd0);
    queue_pixel(0, 0, 0);
    queue_pixel(1, 0, 0);
    queue_pixel(0, 0, 1);
    queue_pixel(1, 1, 0);
    queue_random_batch(170);
    wait_for_drain();

    // Full-scale threshold: only pure white survives.
    write_dark_threshold(8'd255);
    queue_pixel(255, 255, 255);
    queue_pixel(255, 255, 254);
    queue_random_batch(36);
    wait_for_drain();

    write_dark_threshold(8'd128);
    queue_random_batch(140);
    wait_for_drain();

    write_dark_threshold(PixW'($urandom_range(0, 255)));
    queue_random_batch(140);
    wait_for_drain();

    write_dark_threshold(PixW'($urandom_range(1, 30)));
    queue_random_batch(140);
    wait_for_drain();

    write_dark_threshold(8'd1);
    queue_random_batch(140);
    wait_for_drain();

    write_dark_threshold(8'd60);
    queue_random_batch(140);
    wait_for_drain();

    // Catch any stray strobe after the last result.
    repeat (Latency + 5) @(posedge clk);
    if (response_q.size() != 0) begin
      $error("%0d results never arrived", response_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("PASS color_opponent_salience");
    end else begin
      $display("FAIL color_opponent_salience");
    end
    $finish;
  end

endmodule
